// ===== rtl/uict_pkg.sv =====
// Shared definitions for the unmap interval coverage tracker.
// Opcodes, status codes and the controller/datapath command and status structs.
// No dependencies.
package uict_pkg;

  // Item opcodes
  localparam logic [1:0] OP_ADD       = 2'd0;
  localparam logic [1:0] OP_FLUSH_ONE = 2'd1;
  localparam logic [1:0] OP_FLUSH_ALL = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Outcome of the merge check
  localparam logic [1:0] PATH_END = 2'd0;  // result already decided
  localparam logic [1:0] PATH_WM  = 2'd1;  // write merged range only
  localparam logic [1:0] PATH_CPL = 2'd2;  // move tail down, then write
  localparam logic [1:0] PATH_CPR = 2'd3;  // move tail up, then write

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic rd;
    logic p1_ev;
    logic chk;
    logic cp_wr;
    logic wm;
  } dp_cmd_t;

  typedef struct packed {
    logic       scan_last;
    logic       merge_go;
    logic       cnt_zero;
    logic       p1_last;
    logic [1:0] path;
    logic       cp_last;
  } dp_sts_t;

endpackage

// ===== rtl/uict_ctrl.sv =====
// Controller state machine of the unmap interval coverage tracker.
// Sequences the datapath by dp_cmd_t; depends on uict_pkg.
module uict_ctrl import uict_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_P1RD = 4'd3;
  localparam logic [3:0] S_P1EV = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_CPRD = 4'd6;
  localparam logic [3:0] S_CPWR = 4'd7;
  localparam logic [3:0] S_WM   = 4'd8;
  localparam logic [3:0] S_RESP = 4'd9;

  logic [3:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        if (sts_i.merge_go) state_d = sts_i.cnt_zero ? S_CHK : S_P1RD;
        else state_d = S_RESP;
      end
      S_P1RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_P1EV;
      end
      S_P1EV: begin
        cmd_o.p1_ev = 1'b1;
        state_d     = sts_i.p1_last ? S_CHK : S_P1RD;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        case (sts_i.path)
          PATH_END: state_d = S_RESP;
          PATH_WM:  state_d = S_WM;
          default:  state_d = S_CPRD;
        endcase
      end
      S_CPRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CPWR;
      end
      S_CPWR: begin
        cmd_o.cp_wr = 1'b1;
        state_d     = sts_i.cp_last ? S_WM : S_CPRD;
      end
      S_WM: begin
        cmd_o.wm = 1'b1;
        state_d  = S_RESP;
      end
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

// ===== rtl/uict_dp.sv =====
// Datapath of the unmap interval coverage tracker: slot table, range memory,
// merge registers and result registers. Depends on uict_pkg.
module uict_dp import uict_pkg::*; #(
  parameter int CHUNK_SLOTS      = 16,
  parameter int RANGES_PER_CHUNK = 8,
  parameter int OFFSET_BITS      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] chunk_index_i,
  input  logic [31:0] start_offset_i,
  input  logic [31:0] end_offset_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  output logic [1:0]  status_o,
  output logic [3:0]  ranges_held_o
);

  localparam int SW    = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
  localparam int RW    = $clog2(RANGES_PER_CHUNK);
  localparam int CW    = $clog2(RANGES_PER_CHUNK + 1);
  localparam int NW    = $clog2(RANGES_PER_CHUNK + 2);
  localparam int DEPTH = CHUNK_SLOTS * RANGES_PER_CHUNK;
  localparam int AW    = $clog2(DEPTH);
  localparam int OW    = OFFSET_BITS;

  // Slot table
  logic [CHUNK_SLOTS-1:0] slot_valid_q;
  logic [31:0]            slot_chunk_q [CHUNK_SLOTS];
  logic [CW-1:0]          slot_cnt_q   [CHUNK_SLOTS];

  // Range memory
  logic [OW-1:0] rs_mem [DEPTH];
  logic [OW-1:0] re_mem [DEPTH];
  logic [OW-1:0] rd_s_q, rd_e_q;

  // Item and working registers
  logic [1:0]    op_q;
  logic [31:0]   chunk_q;
  logic [OW-1:0] s_q, e_q, len_q;
  logic [SW-1:0] sidx_q, hit_slot_q, free_slot_q, sel_q;
  logic          hit_q, free_found_q;
  logic [RW-1:0] idx_q;
  logic [CW-1:0] cnt_q, p_q, q_q;
  logic [NW-1:0] n_q;
  logic          dir_up_q;
  logic [1:0]    res_status_q;
  logic [3:0]    res_held_q;

  logic          bad_range, go;
  logic [SW-1:0] sel_d;
  logic [NW-1:0] n_d;
  logic          overflow, whole;
  logic [1:0]    path;
  logic [RW-1:0] wr_off;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          mem_we;
  logic [OW-1:0] wd_s, wd_e;

  // Decision and merge check terms
  assign bad_range = (s_q >= e_q) || (e_q > len_q);
  assign go        = (op_q == OP_ADD) && !bad_range && (hit_q || free_found_q);
  assign sel_d     = hit_q ? hit_slot_q : free_slot_q;
  assign n_d       = NW'(p_q) + NW'(1) + NW'(cnt_q) - NW'(q_q);
  assign overflow  = (n_d > NW'(RANGES_PER_CHUNK));
  assign whole     = (n_d == NW'(1)) && (s_q == '0) && (e_q == len_q);

  always_comb begin
    if (overflow || whole) path = PATH_END;
    else if ((q_q == p_q) && (cnt_q > p_q)) path = PATH_CPR;
    else if ((q_q > p_q + CW'(1)) && (q_q < cnt_q)) path = PATH_CPL;
    else path = PATH_WM;
  end

  assign sts_o.scan_last = (sidx_q == SW'(CHUNK_SLOTS - 1));
  assign sts_o.merge_go  = go;
  assign sts_o.cnt_zero  = (slot_cnt_q[sel_d] == '0);
  assign sts_o.p1_last   = (CW'(idx_q) == cnt_q - CW'(1));
  assign sts_o.path      = path;
  assign sts_o.cp_last   = dir_up_q ? (CW'(idx_q) == p_q) : (CW'(idx_q) == cnt_q - CW'(1));

  // Memory addressing: tail moves and the merged range
  assign wr_off  = cmd_i.wm ? RW'(p_q) :
                   dir_up_q ? RW'(CW'(idx_q) + CW'(1)) :
                              RW'(CW'(idx_q) - (q_q - p_q - CW'(1)));
  assign rd_addr = AW'(int'(sel_q) * RANGES_PER_CHUNK + int'(idx_q));
  assign wr_addr = AW'(int'(sel_q) * RANGES_PER_CHUNK + int'(wr_off));
  assign mem_we  = cmd_i.cp_wr || cmd_i.wm;
  assign wd_s    = cmd_i.wm ? s_q : rd_s_q;
  assign wd_e    = cmd_i.wm ? e_q : rd_e_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rs_mem[wr_addr] <= wd_s;
      re_mem[wr_addr] <= wd_e;
    end
    if (cmd_i.rd) begin
      rd_s_q <= rs_mem[rd_addr];
      rd_e_q <= re_mem[rd_addr];
    end
  end

  // Slot table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      for (int i = 0; i < CHUNK_SLOTS; i++) slot_cnt_q[i] <= '0;
      len_q <= OW'(32'hFFFF_FFFF);
    end else begin
      if (cfg_we_i) len_q <= OW'(cfg_data_i);
      if (cmd_i.decide) begin
        if (op_q == OP_FLUSH_ONE && hit_q) begin
          slot_valid_q[hit_slot_q] <= 1'b0;
          slot_cnt_q[hit_slot_q]   <= '0;
        end
        if (op_q == OP_FLUSH_ALL) begin
          slot_valid_q <= '0;
          for (int i = 0; i < CHUNK_SLOTS; i++) slot_cnt_q[i] <= '0;
        end
      end
      if (cmd_i.chk && !overflow && whole) begin
        slot_valid_q[sel_q] <= 1'b0;
        slot_cnt_q[sel_q]   <= '0;
      end
      if (cmd_i.wm) begin
        slot_valid_q[sel_q] <= 1'b1;
        slot_cnt_q[sel_q]   <= CW'(n_q);
      end
    end
  end

  // Slot tags, written with the merged range
  always_ff @(posedge clk_i) begin
    if (cmd_i.wm) slot_chunk_q[sel_q] <= chunk_q;
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= opcode_i;
      chunk_q      <= chunk_index_i;
      s_q          <= OW'(start_offset_i);
      e_q          <= OW'(end_offset_i);
      sidx_q       <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end
    // Tag scan: note the hit and the lowest free slot
    if (cmd_i.scan) begin
      if (slot_valid_q[sidx_q] && slot_chunk_q[sidx_q] == chunk_q) begin
        hit_q      <= 1'b1;
        hit_slot_q <= sidx_q;
      end
      if (!slot_valid_q[sidx_q] && !free_found_q) begin
        free_found_q <= 1'b1;
        free_slot_q  <= sidx_q;
      end
      if (!sts_o.scan_last) sidx_q <= sidx_q + SW'(1);
    end
    if (cmd_i.decide) begin
      sel_q <= sel_d;
      cnt_q <= slot_cnt_q[sel_d];
      p_q   <= '0;
      q_q   <= '0;
      idx_q <= '0;
      if (op_q == OP_ADD) begin
        if (bad_range) begin
          res_status_q <= ST_INVALID;
          res_held_q   <= hit_q ? 4'(slot_cnt_q[hit_slot_q]) : 4'd0;
        end else begin
          res_status_q <= ST_FULL;
          res_held_q   <= 4'd0;
        end
      end else begin
        res_status_q <= (op_q == OP_FLUSH_ONE || op_q == OP_FLUSH_ALL) ? ST_DONE : ST_INVALID;
        res_held_q   <= 4'd0;
      end
    end
    // First pass: prefix, absorbed ranges and merged bounds
    if (cmd_i.p1_ev) begin
      if (rd_e_q < s_q) begin
        p_q <= p_q + CW'(1);
        q_q <= q_q + CW'(1);
      end else if (rd_s_q > e_q) begin
        q_q <= q_q;
      end else begin
        q_q <= q_q + CW'(1);
        if (rd_s_q < s_q) s_q <= rd_s_q;
        if (rd_e_q > e_q) e_q <= rd_e_q;
      end
      if (!sts_o.p1_last) idx_q <= idx_q + RW'(1);
    end
    if (cmd_i.chk) begin
      n_q      <= n_d;
      dir_up_q <= (path == PATH_CPR);
      idx_q    <= (path == PATH_CPR) ? RW'(cnt_q - CW'(1)) : RW'(q_q);
      if (overflow) begin
        res_status_q <= ST_FULL;
        res_held_q   <= 4'(cnt_q);
      end else if (whole) begin
        res_status_q <= ST_DONE;
        res_held_q   <= 4'd0;
      end
    end
    if (cmd_i.cp_wr && !sts_o.cp_last) begin
      idx_q <= dir_up_q ? idx_q - RW'(1) : idx_q + RW'(1);
    end
    if (cmd_i.wm) begin
      res_status_q <= ST_PENDING;
      res_held_q   <= 4'(n_q);
    end
  end

  assign status_o      = res_status_q;
  assign ranges_held_o = res_held_q;

endmodule

// ===== rtl/unmap_interval_coverage_tracker_top.sv =====
// Top level of the unmap interval coverage tracker.
// Joins uict_ctrl and uict_dp; depends on uict_pkg.
//
// One item at a time: busy is high from the accepting edge until the edge that
// ends the result cycle. An item passes through the tag scan over all
// CHUNK_SLOTS slots and the decision, then for an add that goes ahead a read
// and an evaluation per stored range of the chunk (one read port on the range
// memory), the check, a read and a write per range that shifts position, the
// write of the merged range and the result; an add that completes the chunk or
// overflows its list skips the moves and the write. Flushes and rejected adds
// go from the decision to the result. The result is shown for exactly one cycle
// with done_o and cannot be held off. The chunk length register may be written
// whenever busy is low.
module unmap_interval_coverage_tracker_top import uict_pkg::*; #(
  parameter int CHUNK_SLOTS      = 16,
  parameter int RANGES_PER_CHUNK = 8,
  parameter int OFFSET_BITS      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] chunk_index_i,
  input  logic [31:0] start_offset_i,
  input  logic [31:0] end_offset_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  ranges_held_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = !busy;

  uict_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  uict_dp #(
    .CHUNK_SLOTS     (CHUNK_SLOTS),
    .RANGES_PER_CHUNK(RANGES_PER_CHUNK),
    .OFFSET_BITS     (OFFSET_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .chunk_index_i (chunk_index_i),
    .start_offset_i(start_offset_i),
    .end_offset_i  (end_offset_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .status_o      (status_o),
    .ranges_held_o (ranges_held_o)
  );

endmodule

// ===== rtl/uict_checker.sv =====
// Port-level checks for the unmap interval coverage tracker, bound to the top.
// Depends on uict_pkg.
module uict_checker import uict_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic [3:0] ranges_held_o
);

  // Result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item accepted but not busy");

  // A result only appears while an item is in progress
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result while idle");

  // Completion and flushes report no held ranges
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_DONE) |-> (ranges_held_o == 4'd0))
    else $error("done status with ranges held");

endmodule

bind unmap_interval_coverage_tracker_top uict_checker u_chk (.*);
